@@ design/triangle_longest_edge_splitter_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the triangle longest-edge splitter
// Shared concurrent assertion forms, each reset-qualified on an active-low
// synchronous reset.
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_LONGEST_EDGE_SPLITTER_DEFINES_SVH
`define TRIANGLE_LONGEST_EDGE_SPLITTER_DEFINES_SVH

// Condition holds at every clock edge out of reset.
`define TLES_ASSERT_ALWAYS(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (cond)) \
    else $error("tles assertion failed");

// Antecedent implies consequent in the same cycle.
`define TLES_ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("tles assertion failed");

// Antecedent implies consequent in the following cycle.
`define TLES_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("tles assertion failed");

`endif

@@ design/tles_pkg.sv @@
// ----------------------------------------------------------------------------
// tles_pkg
// Types and constants shared by the triangle longest-edge splitter modules.
// ----------------------------------------------------------------------------
package tles_pkg;

  localparam int COORD_W       = 24;
  localparam int NUM_COORD     = 9;
  localparam int EDGE_SQ_W     = 48;
  localparam int DEPTH_W       = 3;
  localparam int MAX_DEPTH_DEF = 6;
  localparam int QUEUE_DEPTH   = 2;

  localparam logic [EDGE_SQ_W-1:0] EDGE_SQ_RESET = 48'd703687441777;
  localparam logic [DEPTH_W-1:0]   DEPTH_RESET   = 3'd6;

  typedef enum logic [0:0] {
    CFG_MAX_EDGE_SQ = 1'b0,
    CFG_DEPTH_LIMIT = 1'b1
  } cfg_idx_t;

  // Nine coordinates: corner k axis a sits at index 3*k+a.
  typedef logic [NUM_COORD-1:0][COORD_W-1:0] tri_t;

  typedef struct packed {
    tri_t                corners;
    logic [DEPTH_W-1:0]  limit;    // effective halving limit, 0 = pass whole
  } item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_NODE,
    ST_EVAL,
    ST_DECIDE,
    ST_EMIT
  } walk_state_t;

endpackage

@@ design/tles_front.sv @@
// ----------------------------------------------------------------------------
// tles_front
// Holds the configuration, classifies each incoming triangle into its
// effective halving limit and queues it for the walker.
// ----------------------------------------------------------------------------
module tles_front #(
  parameter int MAX_DEPTH = tles_pkg::MAX_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  tles_pkg::cfg_idx_t                cfg_index,
  input  logic [tles_pkg::EDGE_SQ_W-1:0]    cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  tles_pkg::tri_t                    in_tri,
  input  logic                              in_keep_whole,
  output logic [tles_pkg::EDGE_SQ_W-1:0]    max_edge_sq,
  output logic                              q_valid,
  output tles_pkg::item_t                   q_item,
  input  logic                              q_pop
);
  import tles_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [EDGE_SQ_W-1:0] max_edge_sq_r;
  logic [DEPTH_W-1:0]   depth_limit_r;

  item_t                queue_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                 push;
  logic                 pop;
  item_t                new_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_edge_sq_r <= EDGE_SQ_RESET;
      depth_limit_r <= DEPTH_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MAX_EDGE_SQ: max_edge_sq_r <= cfg_wdata;
        CFG_DEPTH_LIMIT: depth_limit_r <= cfg_wdata[DEPTH_W-1:0];
        default: ;
      endcase
    end
  end

  assign max_edge_sq = max_edge_sq_r;

  // Classify: keep-whole items get limit zero, others saturate at MAX_DEPTH.
  always_comb begin
    new_item.corners = in_tri;
    if (in_keep_whole) begin
      new_item.limit = '0;
    end else if (depth_limit_r > DEPTH_W'(MAX_DEPTH)) begin
      new_item.limit = DEPTH_W'(MAX_DEPTH);
    end else begin
      new_item.limit = depth_limit_r;
    end
  end

  assign in_stall = (cnt_r == CNT_W'(QUEUE_DEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != '0);
  assign pop      = q_pop && q_valid;
  assign q_item   = queue_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue_r[wr_ptr_r] <= new_item;
    end
  end

endmodule

@@ design/tles_back.sv @@
// ----------------------------------------------------------------------------
// tles_back
// Depth-first bisection walker: one shared squarer measures the edges of the
// current node, the node is split or emitted, and pending second pieces wait
// on a small stack.
// ----------------------------------------------------------------------------
`include "triangle_longest_edge_splitter_defines.svh"

module tles_back #(
  parameter int MAX_DEPTH = tles_pkg::MAX_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [tles_pkg::EDGE_SQ_W-1:0]    max_edge_sq,
  input  logic                              q_valid,
  input  tles_pkg::item_t                   q_item,
  output logic                              q_pop,
  output logic                              out_valid,
  input  logic                              out_stall,
  output tles_pkg::tri_t                    out_tri,
  output logic                              out_last
);
  import tles_pkg::*;

  localparam int SP_W   = $clog2(MAX_DEPTH + 1);
  localparam int SIDX_W = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int SQ_W   = 2 * COORD_W;
  localparam int ACC_W  = SQ_W + 2;

  function automatic logic [COORD_W-1:0] coord(tri_t t, logic [1:0] c, logic [1:0] a);
    logic [3:0] idx;
    idx = {c, 2'b00} - {2'b00, c} + {2'b00, a};
    return t[idx];
  endfunction

  function automatic logic [1:0] next_corner(logic [1:0] c);
    return (c == 2'd2) ? 2'd0 : c + 2'd1;
  endfunction

  function automatic logic [COORD_W-1:0] mid(logic [COORD_W-1:0] a, logic [COORD_W-1:0] b);
    logic signed [COORD_W:0] s;
    s = $signed({a[COORD_W-1], a}) + $signed({b[COORD_W-1], b});
    return s[COORD_W:1];
  endfunction

  walk_state_t          state_r, state_nxt;
  tri_t                 tri_r, tri_nxt;
  logic [DEPTH_W-1:0]   depth_r, depth_nxt;
  logic [DEPTH_W-1:0]   lim_r, lim_nxt;
  tri_t                 stk_tri_r   [MAX_DEPTH];
  logic [DEPTH_W-1:0]   stk_depth_r [MAX_DEPTH];
  logic [SP_W-1:0]      sp_r, sp_nxt;
  logic [SIDX_W-1:0]    push_idx;
  logic [SIDX_W-1:0]    pop_idx;

  logic [1:0]           e_r, e_nxt;
  logic [1:0]           a_r, a_nxt;
  logic                 iss_r, iss_nxt;
  logic [SQ_W-1:0]      prod_r, prod_nxt;
  logic                 pv_r, pv_nxt;
  logic [1:0]           pe_r, pe_nxt;
  logic [1:0]           pa_r, pa_nxt;
  logic [ACC_W-1:0]     acc_r, acc_nxt;
  logic [ACC_W-1:0]     best_r, best_nxt;
  logic [1:0]           sel_r, sel_nxt;
  logic                 sel_valid_r, sel_valid_nxt;

  logic                 out_valid_r, out_valid_nxt;
  tri_t                 out_tri_r;
  logic                 out_last_r;

  logic [COORD_W-1:0]          ce_v, cn_v;
  logic signed [COORD_W:0]     delta;
  logic signed [2*COORD_W+1:0] sq;
  logic [ACC_W-1:0]            sum;
  logic [1:0]                  cj, co;
  logic [COORD_W-1:0]          ci_v, cj_v, co_v, m_v;
  tri_t                        p_tri, q_tri;
  logic                        can_emit;
  logic                        emit_fire;
  logic                        push;

  assign push_idx  = sp_r[SIDX_W-1:0];
  assign pop_idx   = SIDX_W'(sp_r - 1'b1);
  assign can_emit  = !out_valid_r || !out_stall;
  assign emit_fire = (state_r == ST_EMIT) && can_emit;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (q_valid) state_nxt = ST_NODE;
      ST_NODE:   state_nxt = (depth_r >= lim_r) ? ST_EMIT : ST_EVAL;
      ST_EVAL:   if (!iss_r && !pv_r) state_nxt = ST_DECIDE;
      ST_DECIDE: state_nxt = sel_valid_r ? ST_NODE : ST_EMIT;
      ST_EMIT: begin
        if (can_emit) state_nxt = (sp_r == '0) ? ST_IDLE : ST_NODE;
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Split geometry: pieces (i,m,o) and (m,j,o).
  always_comb begin
    cj = next_corner(sel_r);
    co = next_corner(cj);
    p_tri = '0;
    q_tri = '0;
    ci_v = '0;
    cj_v = '0;
    co_v = '0;
    m_v  = '0;
    for (int ax = 0; ax < 3; ax++) begin
      ci_v = coord(tri_r, sel_r, 2'(ax));
      cj_v = coord(tri_r, cj, 2'(ax));
      co_v = coord(tri_r, co, 2'(ax));
      m_v  = mid(ci_v, cj_v);
      p_tri[ax]     = ci_v;
      p_tri[3 + ax] = m_v;
      p_tri[6 + ax] = co_v;
      q_tri[ax]     = m_v;
      q_tri[3 + ax] = cj_v;
      q_tri[6 + ax] = co_v;
    end
  end

  // Squarer input and edge accumulation.
  always_comb begin
    ce_v  = coord(tri_r, e_r, a_r);
    cn_v  = coord(tri_r, next_corner(e_r), a_r);
    delta = $signed({ce_v[COORD_W-1], ce_v}) - $signed({cn_v[COORD_W-1], cn_v});
    sq    = delta * delta;
    sum   = acc_r + {2'b00, prod_r};
  end

  // Datapath and handshake outputs.
  always_comb begin
    tri_nxt       = tri_r;
    depth_nxt     = depth_r;
    lim_nxt       = lim_r;
    sp_nxt        = sp_r;
    e_nxt         = e_r;
    a_nxt         = a_r;
    iss_nxt       = iss_r;
    prod_nxt      = prod_r;
    pv_nxt        = 1'b0;
    pe_nxt        = pe_r;
    pa_nxt        = pa_r;
    acc_nxt       = acc_r;
    best_nxt      = best_r;
    sel_nxt       = sel_r;
    sel_valid_nxt = sel_valid_r;
    q_pop         = 1'b0;
    push          = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          tri_nxt   = q_item.corners;
          lim_nxt   = q_item.limit;
          depth_nxt = '0;
          sp_nxt    = '0;
        end
      end
      ST_NODE: begin
        e_nxt         = 2'd0;
        a_nxt         = 2'd0;
        iss_nxt       = 1'b1;
        acc_nxt       = '0;
        best_nxt      = {2'b00, max_edge_sq};
        sel_valid_nxt = 1'b0;
      end
      ST_EVAL: begin
        if (iss_r) begin
          prod_nxt = sq[SQ_W-1:0];
          pv_nxt   = 1'b1;
          pe_nxt   = e_r;
          pa_nxt   = a_r;
          if (a_r == 2'd2) begin
            a_nxt = 2'd0;
            e_nxt = e_r + 2'd1;
            if (e_r == 2'd2) iss_nxt = 1'b0;
          end else begin
            a_nxt = a_r + 2'd1;
          end
        end
        if (pv_r) begin
          if (pa_r == 2'd2) begin
            acc_nxt = '0;
            if (sum > best_r) begin
              best_nxt      = sum;
              sel_nxt       = pe_r;
              sel_valid_nxt = 1'b1;
            end
          end else begin
            acc_nxt = sum;
          end
        end
      end
      ST_DECIDE: begin
        if (sel_valid_r) begin
          push      = 1'b1;
          tri_nxt   = p_tri;
          depth_nxt = depth_r + 1'b1;
          sp_nxt    = sp_r + 1'b1;
        end
      end
      ST_EMIT: begin
        if (can_emit) begin
          out_valid_nxt = 1'b1;
          if (sp_r != '0) begin
            tri_nxt   = stk_tri_r[pop_idx];
            depth_nxt = stk_depth_r[pop_idx];
            sp_nxt    = sp_r - 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      sp_r        <= '0;
      iss_r       <= 1'b0;
      pv_r        <= 1'b0;
      sel_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sp_r        <= sp_nxt;
      iss_r       <= iss_nxt;
      pv_r        <= pv_nxt;
      sel_valid_r <= sel_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tri_r   <= tri_nxt;
    depth_r <= depth_nxt;
    lim_r   <= lim_nxt;
    e_r     <= e_nxt;
    a_r     <= a_nxt;
    prod_r  <= prod_nxt;
    pe_r    <= pe_nxt;
    pa_r    <= pa_nxt;
    acc_r   <= acc_nxt;
    best_r  <= best_nxt;
    sel_r   <= sel_nxt;
    if (push) begin
      stk_tri_r[push_idx]   <= q_tri;
      stk_depth_r[push_idx] <= depth_r + 1'b1;
    end
    if (emit_fire) begin
      out_tri_r  <= tri_r;
      out_last_r <= (sp_r == '0);
    end
  end

  assign out_valid = out_valid_r;
  assign out_tri   = out_tri_r;
  assign out_last  = out_last_r;

  `TLES_ASSERT_ALWAYS(a_stack_bound, clk, rst_n, sp_r <= SP_W'(MAX_DEPTH))
  `TLES_ASSERT_IMPLY(a_split_below_limit, clk, rst_n, (state_r == ST_DECIDE) && sel_valid_r, depth_r < lim_r)
  `TLES_ASSERT_NEXT(a_last_leaf_ends, clk, rst_n, emit_fire && (sp_r == '0), (state_r == ST_IDLE) && out_valid_r && out_last_r)

endmodule

@@ design/triangle_longest_edge_splitter.sv @@
// ----------------------------------------------------------------------------
// triangle_longest_edge_splitter
// Longest-edge bisection of one Q1.22 triangle into up to 2^MAX_DEPTH leaves.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_*): one beat carries a triangle's three corners and
//   keep_whole. Output channel (out_*): one beat per leaf triangle, emitted in
//   depth-first order, first piece first; last_piece marks the final leaf.
//   Config port (cfg_*): write max_edge_sq (index 0) or depth_limit (index 1)
//   only while the block is idle.
// Timing:
//   A two-entry queue parts the input side from the walker, so new beats are
//   taken while earlier triangles are still being split.
//   Each measured node is loaded, its nine squares run through the one
//   shared 25x25 squarer, the accumulator drains and the node is decided.
//   A leaf at the depth limit is only loaded and emitted; a measured leaf
//   is loaded, measured, decided and emitted. A keep-whole or depth-zero
//   triangle passes from its queue entry through load and emit to the
//   output register; output stalls hold the walk at emit.
// Reset and stall:
//   Synchronous active-low reset empties the queue, the stack and the output
//   register and restores the config defaults. While out_stall is high a
//   valid leaf is held and the walker stops at emit; input beats keep
//   landing in the queue until it is full, then in_stall rises.
// ----------------------------------------------------------------------------
module triangle_longest_edge_splitter #(
  parameter int MAX_DEPTH = tles_pkg::MAX_DEPTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // config write port
  input  logic                                  cfg_we,
  input  tles_pkg::cfg_idx_t                    cfg_index,
  input  logic [tles_pkg::EDGE_SQ_W-1:0]        cfg_wdata,
  // input channel
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [tles_pkg::COORD_W-1:0]   in_corner0_x,
  input  logic signed [tles_pkg::COORD_W-1:0]   in_corner0_y,
  input  logic signed [tles_pkg::COORD_W-1:0]   in_corner0_z,
  input  logic signed [tles_pkg::COORD_W-1:0]   in_corner1_x,
  input  logic signed [tles_pkg::COORD_W-1:0]   in_corner1_y,
  input  logic signed [tles_pkg::COORD_W-1:0]   in_corner1_z,
  input  logic signed [tles_pkg::COORD_W-1:0]   in_corner2_x,
  input  logic signed [tles_pkg::COORD_W-1:0]   in_corner2_y,
  input  logic signed [tles_pkg::COORD_W-1:0]   in_corner2_z,
  input  logic                                  in_keep_whole,
  // result channel
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [tles_pkg::COORD_W-1:0]   out_piece0_x,
  output logic signed [tles_pkg::COORD_W-1:0]   out_piece0_y,
  output logic signed [tles_pkg::COORD_W-1:0]   out_piece0_z,
  output logic signed [tles_pkg::COORD_W-1:0]   out_piece1_x,
  output logic signed [tles_pkg::COORD_W-1:0]   out_piece1_y,
  output logic signed [tles_pkg::COORD_W-1:0]   out_piece1_z,
  output logic signed [tles_pkg::COORD_W-1:0]   out_piece2_x,
  output logic signed [tles_pkg::COORD_W-1:0]   out_piece2_y,
  output logic signed [tles_pkg::COORD_W-1:0]   out_piece2_z,
  output logic                                  out_last_piece
);
  import tles_pkg::*;

  tri_t                 in_tri;
  tri_t                 out_tri;
  item_t                q_item;
  logic                 q_valid;
  logic                 q_pop;
  logic [EDGE_SQ_W-1:0] max_edge_sq;

  // Pack corners as corner*3 + axis.
  assign in_tri[0] = in_corner0_x;
  assign in_tri[1] = in_corner0_y;
  assign in_tri[2] = in_corner0_z;
  assign in_tri[3] = in_corner1_x;
  assign in_tri[4] = in_corner1_y;
  assign in_tri[5] = in_corner1_z;
  assign in_tri[6] = in_corner2_x;
  assign in_tri[7] = in_corner2_y;
  assign in_tri[8] = in_corner2_z;

  // Front: config registers, classification, queue.
  tles_front #(
    .MAX_DEPTH (MAX_DEPTH)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_tri        (in_tri),
    .in_keep_whole (in_keep_whole),
    .max_edge_sq   (max_edge_sq),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_pop         (q_pop)
  );

  // Back: measure, split, walk the stack, emit leaves.
  tles_back #(
    .MAX_DEPTH (MAX_DEPTH)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .max_edge_sq (max_edge_sq),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_tri     (out_tri),
    .out_last    (out_last_piece)
  );

  // Unpack the leaf.
  assign out_piece0_x = out_tri[0];
  assign out_piece0_y = out_tri[1];
  assign out_piece0_z = out_tri[2];
  assign out_piece1_x = out_tri[3];
  assign out_piece1_y = out_tri[4];
  assign out_piece1_z = out_tri[5];
  assign out_piece2_x = out_tri[6];
  assign out_piece2_y = out_tri[7];
  assign out_piece2_z = out_tri[8];

endmodule
